// ===== design/brd_pkg.sv =====
// Package with the beat types and the row dilation function for the binary row dilate block.
package brd_pkg;

    localparam int unsigned WORD_W = 16;
    localparam int unsigned ROW_W  = 2 * WORD_W;

    // Mask bits 30 down to 1: the only positions the run scan visits.
    localparam logic [ROW_W-1:0] SCAN_BITS = {1'b0, {(ROW_W-2){1'b1}}, 1'b0};

    typedef struct packed {
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic [WORD_W-1:0] word_c;
        logic [WORD_W-1:0] word_d;
        logic              first_row;
    } t_in_beat;

    typedef struct packed {
        logic [WORD_W-1:0] out_high;
        logic [WORD_W-1:0] out_low;
    } t_out_beat;

    // Closed form of the sequential run scan. A bit is inside a run when the
    // scanned bit above it is set, and a run starts at a scanned set bit whose
    // upper scanned neighbor is clear. A start marks itself and both neighbors;
    // a run bit marks itself, which also covers the trailing clear bit.
    // Bit 0 is never a run bit, so only a start at bit 1 reaches it.
    function automatic logic [ROW_W-1:0] dilate_row(input logic [ROW_W-1:0] mask);
        logic [ROW_W-1:0] scan;
        logic [ROW_W-1:0] starts;
        logic [ROW_W-1:0] run;
        scan   = mask & SCAN_BITS;
        starts = scan & ~(scan >> 1);
        run    = (scan >> 1) & SCAN_BITS;
        return run | starts | (starts << 1) | (starts >> 1);
    endfunction

endpackage

// ===== design/brd_stream_if.sv =====
// Valid/ready stream interface that carries one payload beat per handshake.
interface brd_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/binary_row_dilate_core.sv =====
// Binary row dilate core: horizontal run dilation of a 32-bit row plus a merge with the row above.
//
// Input channel i_in (sink): one beat is one sprite row, four 16-bit words
// and a first_row flag. Words a and b form the upper half of the mask,
// words c and d the lower half. Output channel o_out (source): one beat per
// input beat, in order, carrying the dilated row ORed with the previous
// row's dilated image (the first row of a frame passes alone).
// A beat is taken at a rising edge where valid and ready are both high.
// A row passes two register stages (input register, result register) on its
// way to o_out. Throughput is one row per cycle while the receiver does not
// stall; the dilation is a fixed shift-and-mask network between the
// two registers, and the previous image register is updated as each row
// moves into the result register.
// When the receiver stalls, the result register holds its beat and the
// input register still takes one more row, so i_in.ready drops only when
// both stages are full.
// Reset (i_rst_n low, synchronous) empties both stages and clears the
// previous image, so a row without first_row after reset passes unchanged.
module binary_row_dilate_core
    import brd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    brd_stream_if.sink          i_in,
    brd_stream_if.source        o_out
);

    logic              r_s1_valid;
    t_in_beat          r_s1_data;
    logic              r_out_valid;
    t_out_beat         r_out_data;
    logic [ROW_W-1:0]  r_prev_image;

    logic              s1_advance;
    logic              in_ready;
    logic [ROW_W-1:0]  row_mask;
    logic [ROW_W-1:0]  n_prev_image;
    logic [ROW_W-1:0]  merged;
    t_out_beat         n_out_data;

    assign s1_advance = r_s1_valid && (!r_out_valid || o_out.ready);
    assign in_ready   = !r_s1_valid || s1_advance;

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    always_comb begin
        row_mask     = {r_s1_data.word_a | r_s1_data.word_b,
                        r_s1_data.word_c | r_s1_data.word_d};
        n_prev_image = dilate_row(row_mask);
        merged       = r_s1_data.first_row ? n_prev_image : (n_prev_image | r_prev_image);
        n_out_data.out_high = merged[ROW_W-1:WORD_W];
        n_out_data.out_low  = merged[WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_image <= '0;
        end else begin
            if (i_in.valid && in_ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_advance) begin
                r_out_valid  <= 1'b1;
                r_prev_image <= n_prev_image;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_s1_data <= i_in.data;
        end
        if (s1_advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== design/brd_checker.sv =====
// Port-level checker for the binary row dilate core and its bind statement.
module brd_checker
    import brd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_beat i_out_data
);

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output beat valid right after reset");

    // A stalled result beat stays and keeps its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output beat changed");

    // With the result stage empty the core must take a row.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while the output stage is empty");

    // Bit 31 is only ever marked together with bit 30 by a run start at bit 30.
    a_top_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.out_high[WORD_W-1] |-> i_out_data.out_high[WORD_W-2])
        else $error("row bit 31 set without bit 30");

endmodule

bind binary_row_dilate_core brd_checker u_brd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
